// ===== rtl/assert_macros.svh =====
// Assertion macros used by the result queue of the frame header decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AX_ASSERT(label, prop, msg)
`define AX_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/ax25hd_pkg.sv =====
// Package with the shared types, codes and decode functions of the frame header decoder.
`timescale 1ns / 1ps

package ax25hd_pkg;

    localparam int MAX_ADDRESSES = 10;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_SUM_W = FIFO_CNT_W + 1;

    localparam logic [2:0] KIND_ADDR  = 3'd0;
    localparam logic [2:0] KIND_CTRL  = 3'd1;
    localparam logic [2:0] KIND_PID   = 3'd2;
    localparam logic [2:0] KIND_INFO  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_COMMAND   = 2'd1;
    localparam logic [1:0] ERR_SHORT     = 2'd2;
    localparam logic [1:0] ERR_ADDR_OVER = 2'd3;

    localparam logic [1:0] FT_INFO  = 2'd0;
    localparam logic [1:0] FT_SUPER = 2'd1;
    localparam logic [1:0] FT_UNNUM = 2'd2;

    localparam logic [3:0] U_UI = 4'd6;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_ADDR,
        PH_CTRL,
        PH_PID,
        PH_INFO,
        PH_DROP
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  addr_index;
        logic [47:0] callsign;
        logic [3:0]  ssid;
        logic        mark_bit;
        logic [1:0]  frame_type;
        logic [2:0]  send_seq;
        logic [2:0]  recv_seq;
        logic [3:0]  sub_code;
        logic [7:0]  data_byte;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    // Trailing blank characters at the low end of the callsign are cleared.
    function automatic logic [47:0] clear_trailing(input logic [47:0] v);
        logic [47:0] r;
        logic        run;
        logic [7:0]  c;
        r   = v;
        run = 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            c = v[8*k +: 8];
            if (run && (c == 8'h00 || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)))
            begin
                r[8*k +: 8] = 8'h00;
            end
            else
            begin
                run = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] u_code(input logic [7:0] c);
        logic [4:0] v;
        logic [3:0] r;
        v = {c[7:5], c[3:2]};
        unique case (v)
            5'h0F:   r = 4'd0;
            5'h07:   r = 4'd1;
            5'h08:   r = 4'd2;
            5'h03:   r = 4'd3;
            5'h0C:   r = 4'd4;
            5'h11:   r = 4'd5;
            5'h00:   r = 4'd6;
            5'h17:   r = 4'd7;
            5'h1C:   r = 4'd8;
            default: r = 4'd9;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] pid_class(input logic [7:0] p);
        logic [3:0] r;
        logic [7:0] m;
        m = p & 8'hCF;
        priority if (p == 8'hFF)
        begin
            r = 4'd14;
        end
        else if (p == 8'hF0)
        begin
            r = 4'd12;
        end
        else
        begin
            unique case (m)
                8'h01:   r = 4'd0;
                8'h06:   r = 4'd1;
                8'h07:   r = 4'd2;
                8'h08:   r = 4'd3;
                8'hC3:   r = 4'd4;
                8'hC4:   r = 4'd5;
                8'hCA:   r = 4'd6;
                8'hCB:   r = 4'd7;
                8'hCC:   r = 4'd8;
                8'hCD:   r = 4'd9;
                8'hCE:   r = 4'd10;
                8'hCF:   r = 4'd11;
                default: r = 4'd13;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== rtl/ax25_frame_header_decoder_unit.sv =====
// Top level of the AX.25 frame header decoder: byte parser followed by a result queue.
// A result is written into the queue when its byte is accepted and is presented from the queue head.
// Throughput: one frame byte per cycle while in_stall is low; a byte that ends an address with an error
// yields two results, which enter the queue together and leave it one at a time.
// in_stall rises while three or more results wait in the four-entry queue.
// Reset (rst_n low, asynchronous) empties the queue and returns to the command byte.
`timescale 1ns / 1ps

module ax25_frame_header_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [3:0]  addr_index,
    output logic [47:0] callsign,
    output logic [3:0]  ssid,
    output logic        mark_bit,
    output logic [1:0]  frame_type,
    output logic [2:0]  send_seq,
    output logic [2:0]  recv_seq,
    output logic [3:0]  sub_code,
    output logic [7:0]  data_byte,
    output logic [1:0]  error_code,
    output logic        last
);

    ax25hd_pkg::result_t res0;
    ax25hd_pkg::result_t res1;
    ax25hd_pkg::result_t head;
    logic [1:0]          res_count;
    logic [1:0]          push_n;
    logic                accept;
    logic                pop;
    logic                no_room;

    assign in_stall = no_room;
    assign accept   = in_valid && !no_room;
    assign push_n   = accept ? res_count : 2'd0;
    assign pop      = out_valid && !out_stall;

    ax25hd_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    ax25hd_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (res0),
        .push1     (res1),
        .push_n    (push_n),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .no_room   (no_room)
    );

    assign kind       = head.kind;
    assign addr_index = head.addr_index;
    assign callsign   = head.callsign;
    assign ssid       = head.ssid;
    assign mark_bit   = head.mark_bit;
    assign frame_type = head.frame_type;
    assign send_seq   = head.send_seq;
    assign recv_seq   = head.recv_seq;
    assign sub_code   = head.sub_code;
    assign data_byte  = head.data_byte;
    assign error_code = head.error_code;
    assign last       = head.last;

endmodule

// ===== rtl/ax25hd_decode.sv =====
// Frame parser: phase state machine and per-byte result decode.
`timescale 1ns / 1ps

module ax25hd_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         frame_byte,
    input  logic               frame_last,
    output ax25hd_pkg::result_t res0,
    output ax25hd_pkg::result_t res1,
    output logic [1:0]         res_count
);

    ax25hd_pkg::phase_t phase_reg;
    ax25hd_pkg::phase_t phase_next;
    logic [2:0]         byte_cnt_reg;
    logic [2:0]         byte_cnt_next;
    logic [3:0]         addr_cnt_reg;
    logic [3:0]         addr_cnt_next;
    logic [47:0]        call_shift_reg;
    logic [47:0]        call_shift_next;
    logic               addr_limit;

    assign addr_limit = ({1'b0, addr_cnt_reg} + 5'd1) >= 5'(ax25hd_pkg::MAX_ADDRESSES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ax25hd_pkg::PH_CMD;
            byte_cnt_reg   <= 3'd0;
            addr_cnt_reg   <= 4'd0;
            call_shift_reg <= 48'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            byte_cnt_reg   <= byte_cnt_next;
            addr_cnt_reg   <= addr_cnt_next;
            call_shift_reg <= call_shift_next;
        end
    end

    always_comb
    begin
        res0            = '0;
        res1            = '0;
        res_count       = 2'd0;
        phase_next      = phase_reg;
        byte_cnt_next   = byte_cnt_reg;
        addr_cnt_next   = addr_cnt_reg;
        call_shift_next = call_shift_reg;

        unique case (phase_reg)
            ax25hd_pkg::PH_CMD:
            begin
                if (frame_byte != 8'h00)
                begin
                    res0.kind       = ax25hd_pkg::KIND_ERROR;
                    res0.error_code = ax25hd_pkg::ERR_COMMAND;
                    res0.last       = 1'b1;
                    res_count       = 2'd1;
                    phase_next      = ax25hd_pkg::PH_DROP;
                end
                else
                begin
                    phase_next      = ax25hd_pkg::PH_ADDR;
                    byte_cnt_next   = 3'd0;
                    addr_cnt_next   = 4'd0;
                    call_shift_next = 48'd0;
                    if (frame_last)
                    begin
                        res0.kind       = ax25hd_pkg::KIND_ERROR;
                        res0.error_code = ax25hd_pkg::ERR_SHORT;
                        res0.last       = 1'b1;
                        res_count       = 2'd1;
                    end
                end
            end
            ax25hd_pkg::PH_ADDR:
            begin
                if (byte_cnt_reg < 3'd6)
                begin
                    call_shift_next = {call_shift_reg[39:0], 1'b0, frame_byte[7:1]};
                    byte_cnt_next   = byte_cnt_reg + 3'd1;
                    if (frame_last)
                    begin
                        res0.kind       = ax25hd_pkg::KIND_ERROR;
                        res0.error_code = ax25hd_pkg::ERR_SHORT;
                        res0.last       = 1'b1;
                        res_count       = 2'd1;
                    end
                end
                else
                begin
                    res0.kind       = ax25hd_pkg::KIND_ADDR;
                    res0.addr_index = addr_cnt_reg;
                    res0.callsign   = ax25hd_pkg::clear_trailing(call_shift_reg);
                    res0.ssid       = frame_byte[4:1];
                    res0.mark_bit   = frame_byte[7];
                    res_count       = 2'd1;
                    byte_cnt_next   = 3'd0;
                    call_shift_next = 48'd0;
                    if (frame_byte[0])
                    begin
                        phase_next = ax25hd_pkg::PH_CTRL;
                        if (frame_last)
                        begin
                            res1.kind       = ax25hd_pkg::KIND_ERROR;
                            res1.error_code = ax25hd_pkg::ERR_SHORT;
                            res1.last       = 1'b1;
                            res_count       = 2'd2;
                        end
                    end
                    else if (addr_limit)
                    begin
                        res1.kind       = ax25hd_pkg::KIND_ERROR;
                        res1.error_code = ax25hd_pkg::ERR_ADDR_OVER;
                        res1.last       = 1'b1;
                        res_count       = 2'd2;
                        phase_next      = ax25hd_pkg::PH_DROP;
                    end
                    else
                    begin
                        addr_cnt_next = addr_cnt_reg + 4'd1;
                        if (frame_last)
                        begin
                            res1.kind       = ax25hd_pkg::KIND_ERROR;
                            res1.error_code = ax25hd_pkg::ERR_SHORT;
                            res1.last       = 1'b1;
                            res_count       = 2'd2;
                        end
                    end
                end
            end
            ax25hd_pkg::PH_CTRL:
            begin
                res0.kind     = ax25hd_pkg::KIND_CTRL;
                res0.mark_bit = frame_byte[4];
                res_count     = 2'd1;
                phase_next    = ax25hd_pkg::PH_INFO;
                if (!frame_byte[0])
                begin
                    res0.frame_type = ax25hd_pkg::FT_INFO;
                    res0.send_seq   = frame_byte[3:1];
                    res0.recv_seq   = frame_byte[7:5];
                    phase_next      = ax25hd_pkg::PH_PID;
                end
                else if (!frame_byte[1])
                begin
                    res0.frame_type = ax25hd_pkg::FT_SUPER;
                    res0.recv_seq   = frame_byte[7:5];
                    res0.sub_code   = {2'b00, frame_byte[3:2]};
                end
                else
                begin
                    res0.frame_type = ax25hd_pkg::FT_UNNUM;
                    res0.sub_code   = ax25hd_pkg::u_code(frame_byte);
                    if (ax25hd_pkg::u_code(frame_byte) == ax25hd_pkg::U_UI)
                    begin
                        phase_next = ax25hd_pkg::PH_PID;
                    end
                end
            end
            ax25hd_pkg::PH_PID:
            begin
                res0.kind      = ax25hd_pkg::KIND_PID;
                res0.mark_bit  = frame_byte[5] ^ frame_byte[4];
                res0.sub_code  = ax25hd_pkg::pid_class(frame_byte);
                res0.data_byte = frame_byte;
                res_count      = 2'd1;
                if (frame_byte != 8'hFF)
                begin
                    phase_next = ax25hd_pkg::PH_INFO;
                end
            end
            ax25hd_pkg::PH_INFO:
            begin
                res0.kind      = ax25hd_pkg::KIND_INFO;
                res0.data_byte = (frame_byte >= 8'h20 && frame_byte <= 8'h7E) ?
                                 frame_byte : 8'h20;
                res_count      = 2'd1;
            end
            ax25hd_pkg::PH_DROP:
            begin
                phase_next = ax25hd_pkg::PH_DROP;
            end
            default:
            begin
                phase_next = ax25hd_pkg::PH_CMD;
            end
        endcase

        if (frame_last)
        begin
            if (res_count == 2'd1)
            begin
                res0.last = 1'b1;
            end
            if (res_count == 2'd2)
            begin
                res1.last = 1'b1;
            end
            phase_next      = ax25hd_pkg::PH_CMD;
            byte_cnt_next   = 3'd0;
            addr_cnt_next   = 4'd0;
            call_shift_next = 48'd0;
        end
    end

endmodule

// ===== rtl/ax25hd_result_fifo.sv =====
// Small result queue that takes up to two results a cycle and hands out one.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ax25hd_result_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  ax25hd_pkg::result_t push0,
    input  ax25hd_pkg::result_t push1,
    input  logic [1:0]          push_n,
    input  logic                pop,
    output ax25hd_pkg::result_t head,
    output logic                not_empty,
    output logic                no_room
);

    ax25hd_pkg::result_t                  mem [ax25hd_pkg::FIFO_DEPTH];
    logic [ax25hd_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [ax25hd_pkg::FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [ax25hd_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [ax25hd_pkg::FIFO_PTR_W-1:0]    rd_ptr_next;
    logic [ax25hd_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [ax25hd_pkg::FIFO_CNT_W-1:0]    count_next;
    logic [ax25hd_pkg::FIFO_PTR_W-1:0]    wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + ax25hd_pkg::FIFO_PTR_W'(1);
    assign head       = mem[rd_ptr_reg];
    assign not_empty  = (count_reg != '0);
    // Room for two results must remain before a new request is taken.
    assign no_room    = count_reg > ax25hd_pkg::FIFO_CNT_W'(ax25hd_pkg::FIFO_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + ax25hd_pkg::FIFO_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + ax25hd_pkg::FIFO_PTR_W'(pop);
    assign count_next  = count_reg + ax25hd_pkg::FIFO_CNT_W'(push_n)
                       - ax25hd_pkg::FIFO_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_inc] <= push1;
        end
    end

    `AX_ASSERT(a_count_bound, count_reg <= ax25hd_pkg::FIFO_CNT_W'(ax25hd_pkg::FIFO_DEPTH), "result queue count exceeds its depth")
    `AX_ASSERT(a_no_overflow, ({1'b0, count_reg} + ax25hd_pkg::FIFO_SUM_W'(push_n)) <= (ax25hd_pkg::FIFO_SUM_W'(ax25hd_pkg::FIFO_DEPTH) + ax25hd_pkg::FIFO_SUM_W'(pop)), "result queue overflow")
    `AX_ASSERT(a_no_underflow, !pop || not_empty, "pop from an empty result queue")
    `AX_ASSERT_NEXT(a_pop_drains, pop && push_n == 2'd0, count_reg == $past(count_reg) - ax25hd_pkg::FIFO_CNT_W'(1), "pop without push did not reduce the count")

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the AX.25 frame header decoder, driven by directed and random frames.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_BYTES = 1500;
    localparam int QUIET_BYTES  = 300;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 60;
    localparam int TABLE_ROWS   = 28;

    localparam logic [3:0] U_SABME = 4'd0;
    localparam logic [3:0] U_SABM  = 4'd1;
    localparam logic [3:0] U_DISC  = 4'd2;
    localparam logic [3:0] U_DM    = 4'd3;
    localparam logic [3:0] U_UA    = 4'd4;
    localparam logic [3:0] U_FRMR  = 4'd5;
    localparam logic [3:0] U_XID   = 4'd7;
    localparam logic [3:0] U_TEST  = 4'd8;
    localparam logic [3:0] U_OTHER = 4'd9;

    localparam logic [3:0] PC_X25      = 4'd0;
    localparam logic [3:0] PC_VJ_COMP  = 4'd1;
    localparam logic [3:0] PC_VJ_RAW   = 4'd2;
    localparam logic [3:0] PC_SEGMENT  = 4'd3;
    localparam logic [3:0] PC_TEXNET   = 4'd4;
    localparam logic [3:0] PC_LQP      = 4'd5;
    localparam logic [3:0] PC_ATALK    = 4'd6;
    localparam logic [3:0] PC_ATALK_AR = 4'd7;
    localparam logic [3:0] PC_IP       = 4'd8;
    localparam logic [3:0] PC_ARP      = 4'd9;
    localparam logic [3:0] PC_FLEXNET  = 4'd10;
    localparam logic [3:0] PC_NETROM   = 4'd11;
    localparam logic [3:0] PC_NONE     = 4'd12;
    localparam logic [3:0] PC_OTHER    = 4'd13;
    localparam logic [3:0] PC_ESCAPE   = 4'd14;

    localparam logic [7:0] PID_ESCAPE = 8'hFF;
    localparam logic [7:0] PID_NONE   = 8'hF0;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       flast;
        logic       typed;
        logic [2:0] wkind;
        logic [1:0] wcode;
        logic [7:0] wdata;
        logic       wlast;
    } stim_row_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  frame_byte = 8'h00;
    logic        frame_last = 1'b0;
    logic        out_stall  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  kind;
    logic [3:0]  addr_index;
    logic [47:0] callsign;
    logic [3:0]  ssid;
    logic        mark_bit;
    logic [1:0]  frame_type;
    logic [2:0]  send_seq;
    logic [2:0]  recv_seq;
    logic [3:0]  sub_code;
    logic [7:0]  data_byte;
    logic [1:0]  error_code;
    logic        last;

    ax25hd_pkg::phase_t  dec_phase   = ax25hd_pkg::PH_CMD;
    logic [2:0]          dec_pos     = 3'd0;
    logic [3:0]          dec_naddr   = 4'd0;
    logic [47:0]         dec_call    = 48'd0;
    logic                dec_pid_due = 1'b0;
    ax25hd_pkg::result_t step_out [0:1];
    int                  step_n;
    ax25hd_pkg::result_t expected_results [$];
    ax25hd_pkg::result_t head_res;

    logic quiet      = 1'b0;
    logic hold_req   = 1'b0;
    int   mismatch_count  = 0;
    int   bytes_sent      = 0;
    int   frames_sent     = 0;
    int   results_checked = 0;
    int   error_results   = 0;
    int   overflow_count  = 0;

    logic [7:0] u_cmds [0:8] = '{8'h6F, 8'h2F, 8'h43, 8'h0F, 8'h63, 8'h87, 8'h03, 8'hAF,
                                 8'hE3};
    logic [7:0] pid_list [0:11] = '{8'h01, 8'h06, 8'h07, 8'h08, 8'hC3, 8'hC4, 8'hCA, 8'hCB,
                                    8'hCC, 8'hCD, 8'hCE, 8'hCF};
    logic [7:0] blank_list [0:6] = '{8'h40, 8'h41, 8'h00, 8'h01, 8'h12, 8'h1A, 8'h1B};

    stim_row_t dir_tab [0:TABLE_ROWS-1] = '{
        '{8'h05, 1'b0, 1'b1, ax25hd_pkg::KIND_ERROR, ax25hd_pkg::ERR_COMMAND, 8'h00, 1'b1},
        '{8'hFF, 1'b0, 1'b0, ax25hd_pkg::KIND_ERROR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h00, 1'b1, 1'b0, ax25hd_pkg::KIND_ERROR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h00, 1'b1, 1'b1, ax25hd_pkg::KIND_ERROR, ax25hd_pkg::ERR_SHORT, 8'h00, 1'b1},
        '{8'hFF, 1'b1, 1'b1, ax25hd_pkg::KIND_ERROR, ax25hd_pkg::ERR_COMMAND, 8'h00, 1'b1},
        '{8'h00, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h60, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h86, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h82, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h98, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h98, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'hE0, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h82, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h84, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h40, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h40, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h40, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h1A, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h7F, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h03, 1'b0, 1'b0, ax25hd_pkg::KIND_CTRL, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b0, ax25hd_pkg::KIND_PID, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'hF0, 1'b0, 1'b0, ax25hd_pkg::KIND_PID, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h7E, 1'b0, 1'b1, ax25hd_pkg::KIND_INFO, ax25hd_pkg::ERR_NONE, 8'h7E, 1'b0},
        '{8'hFF, 1'b1, 1'b1, ax25hd_pkg::KIND_INFO, ax25hd_pkg::ERR_NONE, 8'h20, 1'b1},
        '{8'h00, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h82, 1'b0, 1'b0, ax25hd_pkg::KIND_ADDR, ax25hd_pkg::ERR_NONE, 8'h00, 1'b0},
        '{8'h84, 1'b1, 1'b1, ax25hd_pkg::KIND_ERROR, ax25hd_pkg::ERR_SHORT, 8'h00, 1'b1}
    };

    ax25_frame_header_decoder_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .addr_index (addr_index),
        .callsign   (callsign),
        .ssid       (ssid),
        .mark_bit   (mark_bit),
        .frame_type (frame_type),
        .send_seq   (send_seq),
        .recv_seq   (recv_seq),
        .sub_code   (sub_code),
        .data_byte  (data_byte),
        .error_code (error_code),
        .last       (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [47:0] strip_blanks(input logic [47:0] cs);
        logic [7:0] c;
        logic       done;
        done = 1'b0;
        for (int k = 0; k < 6 && !done; k++)
        begin
            c = cs[8*k +: 8];
            if (c == 8'h00 || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
            begin
                cs[8*k +: 8] = 8'h00;
            end
            else
            begin
                done = 1'b1;
            end
        end
        return cs;
    endfunction

    function automatic logic [3:0] unnumbered_code(input logic [7:0] ctl);
        case (ctl & 8'hEC)
            8'h6C:   return U_SABME;
            8'h2C:   return U_SABM;
            8'h40:   return U_DISC;
            8'h0C:   return U_DM;
            8'h60:   return U_UA;
            8'h84:   return U_FRMR;
            8'h00:   return ax25hd_pkg::U_UI;
            8'hAC:   return U_XID;
            8'hE0:   return U_TEST;
            default: return U_OTHER;
        endcase
    endfunction

    function automatic logic [3:0] protocol_class(input logic [7:0] p);
        if (p == PID_ESCAPE)
        begin
            return PC_ESCAPE;
        end
        if (p == PID_NONE)
        begin
            return PC_NONE;
        end
        case (p & 8'hCF)
            8'h01:   return PC_X25;
            8'h06:   return PC_VJ_COMP;
            8'h07:   return PC_VJ_RAW;
            8'h08:   return PC_SEGMENT;
            8'hC3:   return PC_TEXNET;
            8'hC4:   return PC_LQP;
            8'hCA:   return PC_ATALK;
            8'hCB:   return PC_ATALK_AR;
            8'hCC:   return PC_IP;
            8'hCD:   return PC_ARP;
            8'hCE:   return PC_FLEXNET;
            8'hCF:   return PC_NETROM;
            default: return PC_OTHER;
        endcase
    endfunction

    function automatic void raise_error(input logic [1:0] code);
        step_out[step_n] = '0;
        step_out[step_n].kind = ax25hd_pkg::KIND_ERROR;
        step_out[step_n].error_code = code;
        step_out[step_n].last = 1'b1;
        step_n++;
        dec_phase = ax25hd_pkg::PH_DROP;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fl);
        ax25hd_pkg::result_t r;
        step_n = 0;
        r = '0;
        case (dec_phase)
            ax25hd_pkg::PH_CMD:
            begin
                if (b != 8'h00)
                begin
                    raise_error(ax25hd_pkg::ERR_COMMAND);
                end
                else
                begin
                    dec_phase = ax25hd_pkg::PH_ADDR;
                    dec_pos = 3'd0;
                    dec_naddr = 4'd0;
                    dec_call = 48'd0;
                    dec_pid_due = 1'b0;
                    if (fl)
                    begin
                        raise_error(ax25hd_pkg::ERR_SHORT);
                    end
                end
            end
            ax25hd_pkg::PH_ADDR:
            begin
                if (dec_pos < 3'd6)
                begin
                    dec_call = {dec_call[39:0], 1'b0, b[7:1]};
                    dec_pos++;
                    if (fl)
                    begin
                        raise_error(ax25hd_pkg::ERR_SHORT);
                    end
                end
                else
                begin
                    r.kind = ax25hd_pkg::KIND_ADDR;
                    r.addr_index = dec_naddr;
                    r.callsign = strip_blanks(dec_call);
                    r.ssid = b[4:1];
                    r.mark_bit = b[7];
                    step_out[step_n] = r;
                    step_n++;
                    dec_pos = 3'd0;
                    dec_call = 48'd0;
                    if (b[0])
                    begin
                        dec_phase = ax25hd_pkg::PH_CTRL;
                        if (fl)
                        begin
                            raise_error(ax25hd_pkg::ERR_SHORT);
                        end
                    end
                    else if (int'(dec_naddr) + 1 >= ax25hd_pkg::MAX_ADDRESSES)
                    begin
                        raise_error(ax25hd_pkg::ERR_ADDR_OVER);
                    end
                    else
                    begin
                        dec_naddr++;
                        if (fl)
                        begin
                            raise_error(ax25hd_pkg::ERR_SHORT);
                        end
                    end
                end
            end
            ax25hd_pkg::PH_CTRL:
            begin
                r.kind = ax25hd_pkg::KIND_CTRL;
                r.mark_bit = b[4];
                dec_pid_due = 1'b0;
                if (!b[0])
                begin
                    r.frame_type = ax25hd_pkg::FT_INFO;
                    r.send_seq = b[3:1];
                    r.recv_seq = b[7:5];
                    dec_pid_due = 1'b1;
                end
                else if (!b[1])
                begin
                    r.frame_type = ax25hd_pkg::FT_SUPER;
                    r.recv_seq = b[7:5];
                    r.sub_code = {2'b00, b[3:2]};
                end
                else
                begin
                    r.frame_type = ax25hd_pkg::FT_UNNUM;
                    r.sub_code = unnumbered_code(b);
                    dec_pid_due = (r.sub_code == ax25hd_pkg::U_UI);
                end
                step_out[step_n] = r;
                step_n++;
                dec_phase = dec_pid_due ? ax25hd_pkg::PH_PID : ax25hd_pkg::PH_INFO;
            end
            ax25hd_pkg::PH_PID:
            begin
                r.kind = ax25hd_pkg::KIND_PID;
                r.mark_bit = b[5] ^ b[4];
                r.sub_code = protocol_class(b);
                r.data_byte = b;
                step_out[step_n] = r;
                step_n++;
                if (b != PID_ESCAPE)
                begin
                    dec_phase = ax25hd_pkg::PH_INFO;
                end
            end
            ax25hd_pkg::PH_INFO:
            begin
                r.kind = ax25hd_pkg::KIND_INFO;
                r.data_byte = (b >= 8'h20 && b <= 8'h7E) ? b : 8'h20;
                step_out[step_n] = r;
                step_n++;
            end
            default:
            begin
            end
        endcase
        if (fl)
        begin
            if (step_n > 0)
            begin
                step_out[step_n-1].last = 1'b1;
            end
            dec_phase = ax25hd_pkg::PH_CMD;
            dec_pos = 3'd0;
            dec_naddr = 4'd0;
            dec_call = 48'd0;
            dec_pid_due = 1'b0;
        end
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fl, input logic typed,
                             input ax25hd_pkg::result_t want);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        frame_byte <= b;
        frame_last <= fl;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b, fl);
        if (typed)
        begin
            expected_results.push_back(want);
        end
        else
        begin
            for (int i = 0; i < step_n; i++)
            begin
                expected_results.push_back(step_out[i]);
            end
        end
        bytes_sent++;
        if (fl)
        begin
            frames_sent++;
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] fb [$];
        logic [7:0] c;
        logic [7:0] ctl;
        int         n_addr;
        int         n_name;
        int         n_info;
        int         cut;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            fb.push_back(8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 6)) fb.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            fb.push_back(8'h00);
            n_addr = ($urandom_range(0, 9) == 0) ?
                     $urandom_range(ax25hd_pkg::MAX_ADDRESSES - 1,
                                    ax25hd_pkg::MAX_ADDRESSES + 1) :
                     $urandom_range(1, 4);
            for (int a = 0; a < n_addr; a++)
            begin
                n_name = $urandom_range(0, 6);
                for (int k = 0; k < 6; k++)
                begin
                    if (k >= n_name)
                    begin
                        c = blank_list[$urandom_range(0, 6)];
                    end
                    else if ($urandom_range(0, 2) != 0)
                    begin
                        c = 8'($urandom_range(48, 90)) << 1;
                    end
                    else
                    begin
                        c = 8'($urandom_range(0, 255));
                    end
                    fb.push_back(c);
                end
                c = 8'($urandom_range(0, 255));
                c[0] = (a == n_addr - 1);
                fb.push_back(c);
            end
            ctl = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0: ctl[0] = 1'b0;
                1: ctl[1:0] = 2'b01;
                2: ctl = u_cmds[$urandom_range(0, 8)] | {3'b000, 1'($urandom_range(0, 1)), 4'h0};
                default: ctl[1:0] = 2'b11;
            endcase
            fb.push_back(ctl);
            if ((!ctl[0] || (ctl & 8'hEF) == 8'h03) && $urandom_range(0, 9) != 0)
            begin
                do
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 2)
                    begin
                        c = PID_ESCAPE;
                    end
                    else if (pick < 3)
                    begin
                        c = PID_NONE;
                    end
                    else if (pick < 7)
                    begin
                        c = pid_list[$urandom_range(0, 11)] |
                            {2'b00, 2'($urandom_range(0, 3)), 4'h0};
                    end
                    else
                    begin
                        c = 8'($urandom_range(0, 255));
                    end
                    fb.push_back(c);
                end
                while (c == PID_ESCAPE);
            end
            n_info = $urandom_range(0, 10);
            repeat (n_info)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    fb.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
                else
                begin
                    fb.push_back(8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 9) == 0)
            begin
                cut = $urandom_range(1, fb.size());
                while (fb.size() > cut) void'(fb.pop_back());
            end
        end
        for (int i = 0; i < fb.size(); i++)
        begin
            send_byte(fb[i], i == fb.size() - 1, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                note_mismatch("result with nothing pending, kind", kind, 0);
            end
            else
            begin
                head_res = expected_results.pop_front();
                if (kind !== head_res.kind)
                    note_mismatch("kind", kind, head_res.kind);
                if (addr_index !== head_res.addr_index)
                    note_mismatch("addr_index", addr_index, head_res.addr_index);
                if (callsign !== head_res.callsign)
                    note_mismatch("callsign", callsign, head_res.callsign);
                if (ssid !== head_res.ssid)
                    note_mismatch("ssid", ssid, head_res.ssid);
                if (mark_bit !== head_res.mark_bit)
                    note_mismatch("mark_bit", mark_bit, head_res.mark_bit);
                if (frame_type !== head_res.frame_type)
                    note_mismatch("frame_type", frame_type, head_res.frame_type);
                if (send_seq !== head_res.send_seq)
                    note_mismatch("send_seq", send_seq, head_res.send_seq);
                if (recv_seq !== head_res.recv_seq)
                    note_mismatch("recv_seq", recv_seq, head_res.recv_seq);
                if (sub_code !== head_res.sub_code)
                    note_mismatch("sub_code", sub_code, head_res.sub_code);
                if (data_byte !== head_res.data_byte)
                    note_mismatch("data_byte", data_byte, head_res.data_byte);
                if (error_code !== head_res.error_code)
                    note_mismatch("error_code", error_code, head_res.error_code);
                if (last !== head_res.last)
                    note_mismatch("last", last, head_res.last);
                results_checked++;
                if (head_res.kind == ax25hd_pkg::KIND_ERROR)
                begin
                    error_results++;
                end
                if (head_res.kind == ax25hd_pkg::KIND_ERROR &&
                    head_res.error_code == ax25hd_pkg::ERR_ADDR_OVER)
                begin
                    overflow_count++;
                end
            end
        end
    end

    // Output side stalls in short random bursts and once for a long stretch so requests back up.
    initial
    begin
        int burst;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        ax25hd_pkg::result_t want;
        logic                hold_issued;
        hold_issued = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            want = '0;
            want.kind = dir_tab[i].wkind;
            want.error_code = dir_tab[i].wcode;
            want.data_byte = dir_tab[i].wdata;
            want.last = dir_tab[i].wlast;
            send_byte(dir_tab[i].fbyte, dir_tab[i].flast, dir_tab[i].typed, want);
        end
        while (bytes_sent < TABLE_ROWS + RANDOM_BYTES)
        begin
            if (!hold_issued && bytes_sent >= HOLD_AT)
            begin
                hold_req = 1'b1;
                hold_issued = 1'b1;
            end
            quiet = (bytes_sent >= TABLE_ROWS + RANDOM_BYTES - QUIET_BYTES);
            send_random_frame();
        end
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d frame bytes in %0d frames; %0d results checked, %0d of them errors.",
                 bytes_sent, frames_sent, results_checked, error_results);
        $display("Address field overflows seen: %0d; mismatches counted: %0d.",
                 overflow_count, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
